/* design/rpmsine_pkg.sv */
`timescale 1ns / 1ps
package rpmsine_pkg;

	localparam int SAMPLES_PER_BLOCK = 32;
	localparam int SINE_TABLE_BITS = 8;
	localparam int TAB_N = 1 << SINE_TABLE_BITS;
	localparam int CNT_W = (SAMPLES_PER_BLOCK > 1) ? $clog2(SAMPLES_PER_BLOCK) : 1;

	typedef logic signed [15:0] speed_t;
	typedef logic signed [15:0] sample_t;
	typedef logic [TAB_N-1:0][14:0] sine_tab_t;

	// polynomial coefficients of sin(pi/2 * x), q30
	localparam logic [63:0] C1_Q30 = 64'd1686629713;
	localparam logic [63:0] C3_Q30 = 64'd693598668;
	localparam logic [63:0] C5_Q30 = 64'd85569306;
	localparam logic [63:0] C7_Q30 = 64'd5026996;
	localparam logic [63:0] C9_Q30 = 64'd172272;
	localparam logic [15:0] AMP_FULL = 16'd32767;

	function automatic logic [14:0] quarter_sine(input int unsigned i);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] p;
		logic [63:0] s;
		x = (64'(i) * 64'd2 + 64'd1) << (29 - SINE_TABLE_BITS);
		x2 = (x * x) >> 30;
		p = C9_Q30;
		p = C7_Q30 - ((x2 * p) >> 30);
		p = C5_Q30 - ((x2 * p) >> 30);
		p = C3_Q30 - ((x2 * p) >> 30);
		p = C1_Q30 - ((x2 * p) >> 30);
		s = (x * p) >> 30;
		s = (s * 64'd32767 + (64'd1 << 29)) >> 30;
		if (s > 64'd32767)
			s = 64'd32767;
		return s[14:0];
	endfunction

	function automatic sine_tab_t build_sine_table();
		sine_tab_t tab;
		for (int unsigned i = 0; i < TAB_N; i++)
			tab[i] = quarter_sine(i);
		return tab;
	endfunction

	localparam sine_tab_t SINE_TABLE = build_sine_table();

endpackage

/* design/rpmsine_in_if.sv */
`timescale 1ns / 1ps
interface rpmsine_in_if;
	import rpmsine_pkg::*;

	logic   valid;
	logic   ready;
	speed_t engine_speed;
	logic   limit_mute;

	modport source (output valid, output engine_speed, output limit_mute, input ready);
	modport sink (input valid, input engine_speed, input limit_mute, output ready);
endinterface

/* design/rpmsine_out_if.sv */
`timescale 1ns / 1ps
interface rpmsine_out_if;
	import rpmsine_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample;
	logic    last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink (input valid, input sample, input last_sample, output ready);
endinterface

/* design/rpm_controlled_sine_tone_generator.sv */
`timescale 1ns / 1ps
// Speed-controlled sine tone generator (direct digital synthesis). Each speed transaction
// produces one block of SAMPLES_PER_BLOCK signed 16-bit sine samples, the last one flagged
// with last_sample. The speed is turned into a Q16 fraction of rpm_reference by a restoring
// divider that takes one quotient bit per cycle (skipped when the speed is zero, negative
// or at/above the reference), the phase step is then formed on the shared multiplier, and
// samples are issued one per cycle while the output is not stalled, through a 3-stage
// lookup / multiply / scale pipeline. The next speed transaction is taken once the last
// sample of a block has left the pipeline into the output register. While muted (register
// or per-transaction flag) the samples are zero and the phase accumulator holds. The
// registers sit on an APB port at byte addresses 0, 4, 8, 12 and 16: rpm_reference,
// phase_step_min, phase_step_max, peak_amplitude, mute_enable; write them only while idle.
module rpm_controlled_sine_tone_generator (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [4:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	rpmsine_in_if.sink            speed,
	rpmsine_out_if.source         audio
);
	import rpmsine_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_STEP = 3'd3;
	localparam logic [2:0] ST_RUN  = 3'd4;

	localparam logic [2:0] REG_RPM_REF  = 3'd0;
	localparam logic [2:0] REG_STEP_MIN = 3'd1;
	localparam logic [2:0] REG_STEP_MAX = 3'd2;
	localparam logic [2:0] REG_PEAK     = 3'd3;
	localparam logic [2:0] REG_MUTE     = 3'd4;

	localparam logic [3:0] DIV_LAST = 4'd15;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_BLOCK - 1);

	// configuration registers
	logic [14:0] rpm_reference_q;
	logic [30:0] phase_step_min_q;
	logic [30:0] phase_step_max_q;
	logic [14:0] peak_amplitude_q;
	logic        mute_enable_q;

	// sequencer
	logic [2:0]       state_q;
	logic [14:0]      ref_q;
	logic [14:0]      rem_q;
	logic [15:0]      quo_q;
	logic [3:0]       bit_cnt_q;
	logic             full_q;
	logic             mute_q;
	logic             ge_q;
	logic [30:0]      span_q;
	logic [30:0]      min_q;
	logic [30:0]      frac_q;
	logic [30:0]      step_q;
	logic [31:0]      phase_q;
	logic [CNT_W-1:0] cnt_q;

	// sample pipeline
	logic        v_s1, neg_s1, last_s1;
	logic [14:0] mag_s1;
	logic        v_s2, neg_s2, last_s2;
	logic [29:0] prod_s2;
	logic        out_valid_q, out_last_q;
	sample_t     out_sample_q;

	logic        cfg_wr;
	logic        accept;
	logic        adv;
	logic        issue;
	logic [14:0] ref_eff;
	logic        speed_pos;
	logic [15:0] div_sh;
	logic        div_ge;
	logic [15:0] div_dif;
	logic [30:0] mul_a;
	logic [15:0] mul_b;
	logic [46:0] mul_p;
	logic [SINE_TABLE_BITS-1:0] tab_idx;
	logic [30:0] sc_sum;
	logic [15:0] sc_q0;
	logic [30:0] sc_rem;
	logic [15:0] sc_v;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[4:2])
			REG_RPM_REF:  prdata = {17'd0, rpm_reference_q};
			REG_STEP_MIN: prdata = {1'b0, phase_step_min_q};
			REG_STEP_MAX: prdata = {1'b0, phase_step_max_q};
			REG_PEAK:     prdata = {17'd0, peak_amplitude_q};
			REG_MUTE:     prdata = {31'd0, mute_enable_q};
			default:      prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpm_reference_q  <= 15'd8000;
			phase_step_min_q <= 31'd4473924;
			phase_step_max_q <= 31'd35791394;
			peak_amplitude_q <= 15'd8000;
			mute_enable_q    <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_RPM_REF:  rpm_reference_q  <= pwdata[14:0];
				REG_STEP_MIN: phase_step_min_q <= pwdata[30:0];
				REG_STEP_MAX: phase_step_max_q <= pwdata[30:0];
				REG_PEAK:     peak_amplitude_q <= pwdata[14:0];
				REG_MUTE:     mute_enable_q    <= pwdata[0];
				default:      ;
			endcase
		end
	end

	// pipeline moves whenever the output register is free or being emptied
	assign adv   = !out_valid_q || audio.ready;
	assign issue = (state_q == ST_RUN) && adv;

	assign speed.ready = (state_q == ST_IDLE) && !v_s1 && !v_s2;
	assign accept      = speed.valid && speed.ready;

	assign ref_eff   = (rpm_reference_q == 15'd0) ? 15'd1 : rpm_reference_q;
	assign speed_pos = !speed.engine_speed[15] && (speed.engine_speed[14:0] != 15'd0);

	// one restoring division step: dividend low bits are all zero
	assign div_sh  = {rem_q, 1'b0};
	assign div_ge  = div_sh >= {1'b0, ref_q};
	assign div_dif = div_sh - {1'b0, ref_q};

	// shared multiplier: span * fraction while forming the step, peak * table otherwise
	always_comb begin
		if (state_q == ST_MUL) begin
			mul_a = span_q;
			mul_b = quo_q;
		end else begin
			mul_a = {16'd0, peak_amplitude_q};
			mul_b = {1'b0, mag_s1};
		end
	end
	assign mul_p = {16'd0, mul_a} * {31'd0, mul_b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= 32'd0;
			cnt_q     <= '0;
			bit_cnt_q <= 4'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						bit_cnt_q <= 4'd0;
						if (speed_pos && (speed.engine_speed[14:0] < ref_eff))
							state_q <= ST_DIV;
						else
							state_q <= ST_MUL;
					end
				end
				ST_DIV: begin
					bit_cnt_q <= bit_cnt_q + 4'd1;
					if (bit_cnt_q == DIV_LAST)
						state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_STEP;
				ST_STEP: begin
					cnt_q   <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (issue) begin
						if (!mute_q)
							phase_q <= phase_q + {1'b0, step_q};
						cnt_q <= cnt_q + CNT_W'(1);
						if (cnt_q == CNT_LAST)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ref_q  <= ref_eff;
			rem_q  <= speed.engine_speed[14:0];
			quo_q  <= 16'd0;
			full_q <= speed_pos && (speed.engine_speed[14:0] >= ref_eff);
			mute_q <= mute_enable_q || speed.limit_mute;
			ge_q   <= phase_step_max_q >= phase_step_min_q;
			span_q <= (phase_step_max_q >= phase_step_min_q) ?
				phase_step_max_q - phase_step_min_q : phase_step_min_q - phase_step_max_q;
			min_q  <= phase_step_min_q;
		end
		if (state_q == ST_DIV) begin
			if (div_ge)
				rem_q <= div_dif[14:0];
			else
				rem_q <= div_sh[14:0];
			quo_q <= {quo_q[14:0], div_ge};
		end
		if (state_q == ST_MUL)
			frac_q <= full_q ? span_q : mul_p[46:16];
		if (state_q == ST_STEP)
			step_q <= ge_q ? min_q + frac_q : min_q - frac_q;
	end

	// quadrant 1 and 3 read the quarter wave mirrored
	assign tab_idx = phase_q[31-2 -: SINE_TABLE_BITS] ^ {SINE_TABLE_BITS{phase_q[30]}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= issue;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	// divide by 32767 via reciprocal estimate and one correction
	assign sc_sum = {1'b0, prod_s2} + {16'd0, prod_s2[29:15]};
	assign sc_q0  = sc_sum[30:15];
	assign sc_rem = {1'b0, prod_s2} - {sc_q0[15:0], 15'd0} + {15'd0, sc_q0};
	assign sc_v   = sc_q0 + {15'd0, (sc_rem[15:0] >= AMP_FULL)};

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1       <= mute_q ? 15'd0 : SINE_TABLE[tab_idx];
			neg_s1       <= phase_q[31];
			last_s1      <= cnt_q == CNT_LAST;
			prod_s2      <= mul_p[29:0];
			neg_s2       <= neg_s1;
			last_s2      <= last_s1;
			out_sample_q <= neg_s2 ? -sample_t'(sc_v) : sample_t'(sc_v);
			out_last_q   <= last_s2;
		end
	end

	assign audio.valid       = out_valid_q;
	assign audio.sample      = out_sample_q;
	assign audio.last_sample = out_last_q;

`ifndef SYNTHESIS
	a_div_rem_below_ref: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < ref_q))
		else $error("divider remainder not below divisor");

	a_mul_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (!v_s1 && !v_s2))
		else $error("multiplier shared while samples in flight");

	a_mute_holds_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && mute_q) |=> $stable(phase_q))
		else $error("phase moved during muted block");

	a_step_side: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (ge_q ? (step_q >= min_q) : (step_q <= min_q)))
		else $error("phase step on wrong side of minimum");

	a_last_ends_block: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && (cnt_q == CNT_LAST)) |=> (state_q == ST_IDLE))
		else $error("block did not end after last sample");
`endif

endmodule
